// ===== rtl/core/cro_pkg.sv =====
package cro_pkg;

   localparam int COORD_WIDTH  = 12;
   localparam int RADIUS_WIDTH = 11;
   localparam int CTR_W        = COORD_WIDTH + 1;   // centre, step_y, advanced x
   localparam int POS_W        = 14;                // output coordinate width
   localparam int DEC_W        = 18;                // decision variable width
   localparam int COL_W        = 8;
   localparam int BLEND_W      = 3;
   localparam int IDX_W        = 3;                 // up to eight results per job

   localparam int QUEUE_DEPTH  = 2;
   localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);

   localparam int REQ_DATA_W   = 72;
   localparam int RSP_DATA_W   = 96;

   // input selector carried on req_tuser
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef enum logic [2:0] {
      KIND_START_OUTLINE = 3'd0,
      KIND_START_FILL    = 3'd1,
      KIND_POINTS        = 3'd2,
      KIND_SPANS         = 3'd3,
      KIND_MARKER        = 3'd4
   } cro_kind_type;

   typedef struct packed {
      cro_kind_type              kind;
      logic                      done;
      logic [CTR_W-1:0]          cx;
      logic [CTR_W-1:0]          cy;
      logic [CTR_W-1:0]          x;     // unsigned step x (zero on start)
      logic signed [CTR_W-1:0]   y;     // signed step y (radius on start)
      logic [COL_W-1:0]          red;
      logic [COL_W-1:0]          green;
      logic [COL_W-1:0]          blue;
      logic [COL_W-1:0]          alpha;
      logic [BLEND_W-1:0]        blend;
   } cro_job_type;

endpackage

// ===== rtl/core/circle_rasterizer_outline_fill.sv =====
// Request path: job queue, back end's current job register, registered output stage.
// Throughput: one result word per cycle from the back end's index counter while
//   rsp_tready allows: 4 words per start, 8 per points or spans advance, 1 per marker.
// A two-entry job queue lets the front end take new words while results drain.
// Reset (synchronous, active high) clears the circle state, the queue and the output
//   stage at once; no clearing pass is needed.
module circle_rasterizer_outline_fill
   import cro_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // corner_x[11:0], corner_y[23:12], radius[34:24], fill[35], red[43:36],
   // green[51:44], blue[59:52], alpha[67:60], blend_code[70:68], zero fill above
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // operation[0]: start or advance
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // start_x[13:0], start_y[27:14], end_x[41:28], end_y[55:42], out_red[63:56],
   // out_green[71:64], out_blue[79:72], out_alpha[87:80], out_blend[90:88], zero above
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // draw[0], done_res[1]
   output logic [1:0]             rsp_tuser,
   // last result word of this request
   output logic                   rsp_tlast
);

   // front -> queue
   logic         fq_valid, fq_ready;
   cro_job_type  fq_job;
   // queue -> back
   logic         qb_valid, qb_ready;
   cro_job_type  qb_job;

   // Front end: decodes the request, holds the circle state and runs one
   // midpoint step per advance, producing a job for the back end.
   cro_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (fq_valid),
      .job_ready  (fq_ready),
      .job        (fq_job)
   );

   cro_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   // Back end: walks each job's start, octant point or span words or its marker, one word
   // per cycle while the output is not stalled, into a registered output stage.
   cro_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (qb_valid),
      .job_ready  (qb_ready),
      .job        (qb_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/cro_front.sv =====
module cro_front
   import cro_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   output logic                   job_valid,
   input  logic                   job_ready,
   output cro_job_type            job
);

   logic [CTR_W-1:0]          centre_x_ff, centre_x_in;
   logic [CTR_W-1:0]          centre_y_ff, centre_y_in;
   logic [COORD_WIDTH-1:0]    step_x_ff, step_x_in;
   logic signed [CTR_W-1:0]   step_y_ff, step_y_in;
   logic signed [DEC_W-1:0]   decision_ff, decision_in;
   logic [4*COL_W-1:0]        colour_ff, colour_in;
   logic [BLEND_W-1:0]        blend_ff, blend_in;
   logic                      fill_ff, fill_in;
   logic                      active_ff, active_in;

   logic [COORD_WIDTH-1:0]    in_corner_x, in_corner_y;
   logic [RADIUS_WIDTH-1:0]   in_radius;
   logic                      in_fill;
   logic [4*COL_W-1:0]        in_colour;
   logic [BLEND_W-1:0]        in_blend;

   logic                      accept;
   logic [CTR_W-1:0]          start_cx, start_cy;
   logic [CTR_W-1:0]          x_adv;
   logic signed [CTR_W-1:0]   y_adv;
   logic                      d_pos;
   logic signed [DEC_W-1:0]   diff4, d_adv;
   logic signed [POS_W-1:0]   xs, ys;
   logic [4*COL_W-1:0]        job_colour;

   // tdata: corner_x, corner_y, radius, fill, red, green, blue, alpha, blend_code
   assign in_corner_x = req_tdata[11:0];
   assign in_corner_y = req_tdata[23:12];
   assign in_radius   = req_tdata[34:24];
   assign in_fill     = req_tdata[35];
   assign in_colour   = {req_tdata[43:36], req_tdata[51:44], req_tdata[59:52],
                         req_tdata[67:60]};
   assign in_blend    = req_tdata[70:68];

   assign req_tready = job_ready;
   assign job_valid  = req_tvalid;
   assign accept     = req_tvalid && job_ready;

   assign start_cx = CTR_W'(in_corner_x) + CTR_W'(in_radius);
   assign start_cy = CTR_W'(in_corner_y) + CTR_W'(in_radius);

   // one midpoint iteration
   assign x_adv = CTR_W'(step_x_ff) + CTR_W'(1);
   assign d_pos = decision_ff > 0;
   assign y_adv = d_pos ? (step_y_ff - CTR_W'(1)) : step_y_ff;
   assign diff4 = (DEC_W'(x_adv) - DEC_W'(y_adv)) <<< 2;
   assign d_adv = d_pos ? (decision_ff + diff4 + DEC_W'(10))
                        : (decision_ff + (DEC_W'(x_adv) << 2) + DEC_W'(6));
   assign xs    = $signed({1'b0, x_adv});
   assign ys    = POS_W'(y_adv);

   assign job_colour = (req_tuser == OP_START) ? in_colour : colour_ff;

   always_comb begin
      job.red   = job_colour[31:24];
      job.green = job_colour[23:16];
      job.blue  = job_colour[15:8];
      job.alpha = job_colour[7:0];
      job.blend = (req_tuser == OP_START) ? in_blend : blend_ff;
      job.cx    = centre_x_ff;
      job.cy    = centre_y_ff;
      job.x     = x_adv;
      job.y     = y_adv;
      job.done  = ys < xs;
      if (req_tuser == OP_START) begin
         job.kind = in_fill ? KIND_START_FILL : KIND_START_OUTLINE;
         job.done = 1'b0;
         job.cx   = start_cx;
         job.cy   = start_cy;
         job.x    = '0;
         job.y    = $signed(CTR_W'(in_radius));
      end else if (!active_ff) begin
         job.kind = KIND_MARKER;
         job.done = 1'b1;
      end else if (!fill_ff) begin
         job.kind = KIND_POINTS;
      end else if (xs < ys) begin
         job.kind = KIND_SPANS;
      end else begin
         job.kind = KIND_MARKER;
      end
   end

   always_comb begin
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      decision_in = decision_ff;
      colour_in   = colour_ff;
      blend_in    = blend_ff;
      fill_in     = fill_ff;
      active_in   = active_ff;
      if (accept) begin
         if (req_tuser == OP_START) begin
            centre_x_in = start_cx;
            centre_y_in = start_cy;
            step_x_in   = '0;
            step_y_in   = $signed(CTR_W'(in_radius));
            decision_in = DEC_W'(3) - (DEC_W'(in_radius) << 1);
            colour_in   = in_colour;
            blend_in    = in_blend;
            fill_in     = in_fill;
            active_in   = 1'b1;
         end else if (active_ff) begin
            step_x_in   = x_adv[COORD_WIDTH-1:0];
            step_y_in   = y_adv;
            decision_in = d_adv;
            active_in   = !(ys < xs);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         step_x_ff   <= '0;
         step_y_ff   <= '0;
         decision_ff <= '0;
         colour_ff   <= '0;
         blend_ff    <= '0;
         fill_ff     <= 1'b0;
         active_ff   <= 1'b0;
      end else begin
         centre_x_ff <= centre_x_in;
         centre_y_ff <= centre_y_in;
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         decision_ff <= decision_in;
         colour_ff   <= colour_in;
         blend_ff    <= blend_in;
         fill_ff     <= fill_in;
         active_ff   <= active_in;
      end
   end

endmodule

// ===== rtl/core/cro_queue.sv =====
module cro_queue
   import cro_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  cro_job_type  push_job,
   output logic         pop_valid,
   input  logic         pop_ready,
   output cro_job_type  pop_job
);

   cro_job_type          entry_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]     count_ff, count_in;
   logic                 push, pop;

   assign push_ready = count_ff != (Q_PTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/cro_back.sv =====
module cro_back
   import cro_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  cro_job_type            job,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   cro_job_type               cur_ff, cur_in;
   logic                      cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic [1:0]                rsp_user_ff;
   logic                      rsp_last_ff;

   logic                      fire, take, is_last;
   logic [IDX_W-1:0]          last_idx;
   logic signed [POS_W-1:0]   cx, cy, px, py;
   logic signed [POS_W-1:0]   cxpx, cxmx, cxpy, cxmy, cypx, cymx, cypy, cymy;
   logic signed [POS_W-1:0]   cxpx1, cxmx1;
   logic signed [POS_W-1:0]   sx, sy, ex, ey;
   logic                      draw;

   assign fire = cur_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      case (cur_ff.kind)
         KIND_START_OUTLINE, KIND_START_FILL: last_idx = IDX_W'(3);
         KIND_POINTS, KIND_SPANS:             last_idx = IDX_W'(7);
         default:                             last_idx = '0;
      endcase
   end

   assign is_last   = idx_ff == last_idx;
   assign take      = !cur_valid_ff || (fire && is_last);
   assign job_ready = take;

   // extend to output width; results wrap in two's complement
   assign cx = $signed(POS_W'(cur_ff.cx));
   assign cy = $signed(POS_W'(cur_ff.cy));
   assign px = $signed(POS_W'(cur_ff.x));
   assign py = POS_W'(cur_ff.y);

   assign cxpx  = cx + px;
   assign cxmx  = cx - px;
   assign cxpy  = cx + py;
   assign cxmy  = cx - py;
   assign cypx  = cy + px;
   assign cymx  = cy - px;
   assign cypy  = cy + py;
   assign cymy  = cy - py;
   assign cxpx1 = cxpx + POS_W'(1);
   assign cxmx1 = cxmx - POS_W'(1);

   always_comb begin
      sx   = '0;
      sy   = '0;
      ex   = '0;
      ey   = '0;
      draw = 1'b1;
      case (cur_ff.kind)
         KIND_START_OUTLINE: begin
            case (idx_ff[1:0])
               2'd0:    begin sx = cx;   sy = cypy; end
               2'd1:    begin sx = cxpy; sy = cy;   end
               2'd2:    begin sx = cx;   sy = cymy; end
               default: begin sx = cxmy; sy = cy;   end
            endcase
            ex = sx;
            ey = sy;
         end
         KIND_START_FILL: begin
            sx = cx;
            sy = cy;
            case (idx_ff[1:0])
               2'd0:    begin ex = cx;   ey = cymy; end
               2'd1:    begin ex = cx;   ey = cypy; end
               2'd2:    begin ex = cxmy; ey = cy;   end
               default: begin ex = cxpy; ey = cy;   end
            endcase
         end
         KIND_POINTS: begin
            case (idx_ff)
               3'd0:    begin sx = cxpx; sy = cymy; end
               3'd1:    begin sx = cxpx; sy = cypy; end
               3'd2:    begin sx = cxmx; sy = cymy; end
               3'd3:    begin sx = cxmx; sy = cypy; end
               3'd4:    begin sx = cxpy; sy = cymx; end
               3'd5:    begin sx = cxpy; sy = cypx; end
               3'd6:    begin sx = cxmy; sy = cymx; end
               default: begin sx = cxmy; sy = cypx; end
            endcase
            ex = sx;
            ey = sy;
         end
         KIND_SPANS: begin
            // horizontal spans reach one pixel past the diagonal column
            case (idx_ff)
               3'd0:    begin sx = cxpx; sy = cymy; ex = cxpx;  ey = cymx; end
               3'd1:    begin sx = cxpy; sy = cymx; ex = cxpx1; ey = cymx; end
               3'd2:    begin sx = cxpx; sy = cypy; ex = cxpx;  ey = cypx; end
               3'd3:    begin sx = cxpy; sy = cypx; ex = cxpx1; ey = cypx; end
               3'd4:    begin sx = cxmx; sy = cypy; ex = cxmx;  ey = cypx; end
               3'd5:    begin sx = cxmy; sy = cypx; ex = cxmx1; ey = cypx; end
               3'd6:    begin sx = cxmx; sy = cymy; ex = cxmx;  ey = cymx; end
               default: begin sx = cxmy; sy = cymx; ex = cxmx1; ey = cymx; end
            endcase
         end
         default: begin
            draw = 1'b0;
         end
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (fire) begin
         idx_in = idx_ff + 1'b1;
      end
      if (take) begin
         cur_valid_in = job_valid;
         idx_in       = '0;
         if (job_valid) begin
            cur_in = job;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (fire) begin
         rsp_data_ff <= {5'b0, cur_ff.blend, cur_ff.alpha, cur_ff.blue, cur_ff.green,
                         cur_ff.red, ey, ex, sy, sx};
         rsp_user_ff <= {cur_ff.done, draw};
         rsp_last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== dv/circle_rasterizer_outline_fill_tb.sv =====
module circle_rasterizer_outline_fill_tb
   import cro_pkg::*;
();

   localparam int ITEMS = 460;        // rough length of the whole run, in request words
   localparam int LIMIT = 600000;     // cycle ceiling, several times the slowest legal run
   localparam int DRAIN = 16;         // settle time after the last expected word

   // one request word, unpacked
   typedef struct packed {
      logic                    op;
      logic [COORD_WIDTH-1:0]  corner_x;
      logic [COORD_WIDTH-1:0]  corner_y;
      logic [RADIUS_WIDTH-1:0] radius;
      logic                    fill;
      logic [COL_W-1:0]        red;
      logic [COL_W-1:0]        green;
      logic [COL_W-1:0]        blue;
      logic [COL_W-1:0]        alpha;
      logic [BLEND_W-1:0]      blend;
   } circle_cmd_type;

   // one point or span word as the block should emit it
   typedef struct {
      logic [POS_W-1:0]   sx, sy, ex, ey;
      logic [COL_W-1:0]   red, green, blue, alpha;
      logic [BLEND_W-1:0] blend;
      logic               draw, last, done;
   } span_word_type;

   // Circle tracker plus the queue of point/span words still owed by the block.
   class circle_scoreboard_type;
      logic [CTR_W-1:0]         ctr_x, ctr_y;
      logic [COORD_WIDTH-1:0]   px;
      logic signed [CTR_W-1:0]  py;
      logic signed [DEC_W-1:0]  dvar;
      logic [31:0]              colour_word;
      logic [BLEND_W-1:0]       blend_code;
      logic                     fill_mode;
      logic                     busy;
      span_word_type            expected_words[$];
      int                       errors;
      int                       n_checked;

      function new();
         ctr_x = '0; ctr_y = '0; px = '0; py = '0; dvar = '0;
         colour_word = '0; blend_code = '0; fill_mode = 1'b0; busy = 1'b0;
         errors = 0; n_checked = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // queue one word; coordinates wrap to the 14-bit output field
      function void add_word(int sx, int sy, int ex, int ey, logic draw, logic done);
         span_word_type w;
         w.sx = sx[POS_W-1:0];
         w.sy = sy[POS_W-1:0];
         w.ex = ex[POS_W-1:0];
         w.ey = ey[POS_W-1:0];
         {w.red, w.green, w.blue, w.alpha} = colour_word;
         w.blend = blend_code;
         w.draw = draw;
         w.last = 1'b0;
         w.done = done;
         expected_words.push_back(w);
      endfunction

      function void add_point(int x, int y, logic done);
         add_word(x, y, x, y, 1'b1, done);
      endfunction

      function void note_request(circle_cmd_type c);
         int  r, x, y, cx, cy;
         logic done;
         if (c.op == OP_START) begin
            // new circle, any circle in flight is dropped
            r = int'(c.radius);
            ctr_x = CTR_W'(int'(c.corner_x) + r);
            ctr_y = CTR_W'(int'(c.corner_y) + r);
            px = '0;
            py = CTR_W'(r);
            dvar = DEC_W'(3 - 2 * r);
            fill_mode = c.fill;
            colour_word = {c.red, c.green, c.blue, c.alpha};
            blend_code = c.blend;
            busy = 1'b1;
            cx = int'(ctr_x);
            cy = int'(ctr_y);
            if (fill_mode) begin
               add_word(cx, cy, cx, cy - r, 1'b1, 1'b0);
               add_word(cx, cy, cx, cy + r, 1'b1, 1'b0);
               add_word(cx, cy, cx - r, cy, 1'b1, 1'b0);
               add_word(cx, cy, cx + r, cy, 1'b1, 1'b0);
            end else begin
               add_point(cx, cy + r, 1'b0);
               add_point(cx + r, cy, 1'b0);
               add_point(cx, cy - r, 1'b0);
               add_point(cx - r, cy, 1'b0);
            end
         end else if (!busy) begin
            // nothing to step: lone marker, state untouched
            add_word(0, 0, 0, 0, 1'b0, 1'b1);
         end else begin
            x = int'(px) + 1;
            y = int'(py);
            if (dvar > 0) begin
               y = y - 1;
               dvar = DEC_W'(int'(dvar) + 4 * (x - y) + 10);
            end else begin
               dvar = DEC_W'(int'(dvar) + 4 * x + 6);
            end
            px = x[COORD_WIDTH-1:0];
            py = y[CTR_W-1:0];
            done = (y < x);
            if (done) busy = 1'b0;
            cx = int'(ctr_x);
            cy = int'(ctr_y);
            if (!fill_mode) begin
               add_point(cx + x, cy - y, done);
               add_point(cx + x, cy + y, done);
               add_point(cx - x, cy - y, done);
               add_point(cx - x, cy + y, done);
               add_point(cx + y, cy - x, done);
               add_point(cx + y, cy + x, done);
               add_point(cx - y, cy - x, done);
               add_point(cx - y, cy + x, done);
            end else if (x < y) begin
               // horizontal spans reach one pixel past the inner column
               add_word(cx + x, cy - y, cx + x, cy - x, 1'b1, done);
               add_word(cx + y, cy - x, cx + x + 1, cy - x, 1'b1, done);
               add_word(cx + x, cy + y, cx + x, cy + x, 1'b1, done);
               add_word(cx + y, cy + x, cx + x + 1, cy + x, 1'b1, done);
               add_word(cx - x, cy + y, cx - x, cy + x, 1'b1, done);
               add_word(cx - y, cy + x, cx - x - 1, cy + x, 1'b1, done);
               add_word(cx - x, cy - y, cx - x, cy - x, 1'b1, done);
               add_word(cx - y, cy - x, cx - x - 1, cy - x, 1'b1, done);
            end else begin
               add_word(0, 0, 0, 0, 1'b0, done);
            end
         end
         expected_words[expected_words.size() - 1].last = 1'b1;
      endfunction

      task report(string msg);
         $display("%s", msg);
         errors++;
      endtask

      task cmp_field(string name, int got, int want);
         if (got != want)
            report($sformatf("word %0d: %s got %0h want %0h", n_checked, name, got, want));
      endtask

      task check_word(logic [RSP_DATA_W-1:0] d, logic [1:0] u, logic l);
         span_word_type w;
         if (expected_words.size() == 0) begin
            report($sformatf("word %0d: nothing expected, got %h", n_checked, d));
         end else begin
            w = expected_words.pop_front();
            cmp_field("start_x",   int'(d[13:0]),  int'(w.sx));
            cmp_field("start_y",   int'(d[27:14]), int'(w.sy));
            cmp_field("end_x",     int'(d[41:28]), int'(w.ex));
            cmp_field("end_y",     int'(d[55:42]), int'(w.ey));
            cmp_field("out_red",   int'(d[63:56]), int'(w.red));
            cmp_field("out_green", int'(d[71:64]), int'(w.green));
            cmp_field("out_blue",  int'(d[79:72]), int'(w.blue));
            cmp_field("out_alpha", int'(d[87:80]), int'(w.alpha));
            cmp_field("out_blend", int'(d[90:88]), int'(w.blend));
            cmp_field("draw",      int'(u[0]),     int'(w.draw));
            cmp_field("done_res",  int'(u[1]),     int'(w.done));
            cmp_field("last",      int'(l),        int'(w.last));
         end
         n_checked++;
      endtask
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // corner_x, corner_y, radius, fill, red, green, blue, alpha, blend_code, zero pad
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   // operation
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // start_x, start_y, end_x, end_y, out_red, out_green, out_blue, out_alpha,
   // out_blend, zero pad
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // draw, done_res
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;

   circle_scoreboard_type sb = new();

   int cycles     = 0;
   int items_sent = 0;
   int tx_burst   = 0;   // words left in a no-gap stretch on the request side
   int rx_burst   = 0;   // cycles left in a no-stall stretch on the result side
   int rx_hold    = 0;   // stall cycles still to serve

   circle_rasterizer_outline_fill uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle length: mostly none, often a few cycles, now and then a long one
   function int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function logic [COORD_WIDTH-1:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return COORD_WIDTH'($urandom);
   endfunction

   function circle_cmd_type rand_cmd();
      circle_cmd_type c;
      c.op       = OP_ADVANCE;
      c.corner_x = rand_coord();
      c.corner_y = rand_coord();
      c.radius   = RADIUS_WIDTH'($urandom);
      c.fill     = 1'($urandom);
      c.red      = COL_W'($urandom);
      c.green    = COL_W'($urandom);
      c.blue     = COL_W'($urandom);
      c.alpha    = COL_W'($urandom);
      // codes above mul are rare but legal, passed straight through
      c.blend    = ($urandom_range(0, 9) == 0) ? BLEND_W'($urandom_range(5, 7))
                                               : BLEND_W'($urandom_range(0, 4));
      return c;
   endfunction

   function circle_cmd_type mk_start(int cx, int cy, int r, logic fill,
                                     logic [31:0] rgba, int blend);
      circle_cmd_type c;
      c.op       = OP_START;
      c.corner_x = COORD_WIDTH'(cx);
      c.corner_y = COORD_WIDTH'(cy);
      c.radius   = RADIUS_WIDTH'(r);
      c.fill     = fill;
      {c.red, c.green, c.blue, c.alpha} = rgba;
      c.blend    = BLEND_W'(blend);
      return c;
   endfunction

   // advance words carry random payload, which the block must ignore
   function circle_cmd_type mk_adv();
      circle_cmd_type c;
      c = rand_cmd();
      c.op = OP_ADVANCE;
      return c;
   endfunction

   // Drive one request word and hold it until taken. Valid is only lowered
   // when a gap follows, so it never toggles twice in one step.
   task send(circle_cmd_type c);
      int gap;
      if (tx_burst > 0) begin
         tx_burst--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 49) == 0) tx_burst = $urandom_range(10, 40);
         gap = idle_len();
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.op;
      req_tdata  <= {1'b0, c.blend, c.alpha, c.blue, c.green, c.red, c.fill,
                     c.radius, c.corner_y, c.corner_x};
      do @(posedge clock); while (!req_tready);
      sb.note_request(c);
      items_sent++;
   endtask

   // result side: random stalls, with occasional long stretches of steady ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rx_burst > 0) begin
               rx_burst--;
            end else begin
               if ($urandom_range(0, 99) == 0) rx_burst = $urandom_range(20, 80);
               if ($urandom_range(0, 2) == 0) rx_hold = idle_len();
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT) begin
         $display("circle_rasterizer_outline_fill_tb NOT OK");
         $finish;
      end
   end

   initial begin
      circle_cmd_type c;
      int sel, cap, steps;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // advance with no circle yet: marker in reset colour
      send(mk_adv());
      // zero radius outline: four points on the centre, one advance finishes it
      send(mk_start(0, 0, 0, 1'b0, 32'h0000_0000, 0));
      send(mk_adv());
      // circle finished: idle marker in the latched colour
      send(mk_adv());
      // zero radius fill at the far corner, max colour, mul blend
      send(mk_start(4095, 4095, 0, 1'b1, 32'hFFFF_FFFF, 4));
      send(mk_adv());
      // largest outline at the far corner: coordinates near the top of the 14-bit output range
      send(mk_start(4095, 4095, 2047, 1'b0, 32'hFF00_FF00, 7));
      send(mk_adv());
      send(mk_adv());
      // restart mid-circle, largest fill with its corner at the origin (coordinates down to zero)
      send(mk_start(0, 0, 2047, 1'b1, 32'h00FF_00FF, 5));
      send(mk_adv());
      send(mk_adv());
      // small fill run to completion, ends on markers once x catches y
      send(mk_start(100, 200, 3, 1'b1, 32'h1234_5678, 6));
      send(mk_adv());
      send(mk_adv());
      send(mk_adv());
      send(mk_adv());
      // tiny outline, then two more blend codes
      send(mk_start(10, 10, 1, 1'b0, 32'hA5A5_5A5A, 1));
      send(mk_adv());
      send(mk_adv());
      send(mk_start(12'h555, 12'hAAA, 5, 1'b0, 32'h55AA_55AA, 2));
      send(mk_adv());
      send(mk_start(12'hAAA, 12'h555, 1024, 1'b1, 32'hAA55_AA55, 3));
      send(mk_adv());

      // ---- random: mostly whole circles, some abandoned, some stray words ----
      while (items_sent < ITEMS) begin
         if ($urandom_range(0, 99) < 8) begin
            c = rand_cmd();
            c.op = 1'($urandom);
            send(c);
         end else begin
            c = rand_cmd();
            c.op = OP_START;
            sel = $urandom_range(0, 99);
            if (sel < 70)      c.radius = RADIUS_WIDTH'($urandom_range(0, 24));
            else if (sel < 90) c.radius = RADIUS_WIDTH'($urandom_range(25, 60));
            // big radius: only a few steps, then the circle is dropped
            if (int'(c.radius) > 60)                cap = $urandom_range(1, 6);
            else if ($urandom_range(0, 6) == 0)     cap = $urandom_range(0, int'(c.radius));
            else                                    cap = 1 << 20;
            send(c);
            steps = 0;
            while (sb.busy && steps < cap && items_sent < ITEMS) begin
               send(mk_adv());
               steps++;
            end
            if ($urandom_range(0, 3) == 0) send(mk_adv());
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("circle_rasterizer_outline_fill_tb OK");
      else
         $display("circle_rasterizer_outline_fill_tb NOT OK");
      $finish;
   end

endmodule
